[rtl/core/palette_texture_expand_macros.svh]
// Assertion macros shared by the palette expander checker.
`ifndef PALETTE_TEXTURE_EXPAND_MACROS_SVH
`define PALETTE_TEXTURE_EXPAND_MACROS_SVH

// Property checked only outside reset.
`define PTE_ASSERT(lbl, clk, rst, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Property checked at every edge, reset included.
`define PTE_ASSERT_ALWAYS(lbl, clk, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

[rtl/core/pte_pkg.sv]
// Shared types and constants of the palette expander.
package pte_pkg;

  localparam int unsigned PALETTE_ENTRIES = 256;

  localparam logic OP_LOAD    = 1'b0;
  localparam logic OP_CONVERT = 1'b1;

  localparam logic [7:0]  KEY_ENTRY  = 8'd255;
  localparam logic [23:0] GLASS_KEY  = 24'hFFFFFF;
  localparam logic [23:0] COLOR_KEY  = 24'h0000FF;
  localparam logic [7:0]  FULL_ALPHA = 8'hFF;
  localparam logic [7:0]  ZERO_BYTE  = 8'h00;

  localparam int unsigned QUEUE_DEPTH = 4;
  localparam int unsigned QPTR_W      = 2;
  localparam int unsigned QCNT_W      = 3;

  localparam int unsigned REG_SEL_BIT    = 2;
  localparam logic        REG_DECAL_NAME = 1'b0;
  localparam logic        REG_FILL_ERROR = 1'b1;

  typedef struct packed {
    logic decal_name;
    logic fill_error;
  } cfg_t;

  typedef struct packed {
    logic        is_load;
    logic        in_range;
    logic [7:0]  index;
    logic [23:0] rgb;
  } req_t;

  typedef struct packed {
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
    logic [7:0] alpha;
    logic       alpha_used;
  } res_t;

endpackage

[rtl/core/pte_front.sv]
// Front end: classifies incoming requests and queues them for the back end.
module pte_front #(
  parameter int unsigned PALETTE_ENTRIES = pte_pkg::PALETTE_ENTRIES
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              push,
  output logic              full,
  input  logic              opcode,
  input  logic [7:0]        entry_index,
  input  logic [7:0]        entry_red,
  input  logic [7:0]        entry_green,
  input  logic [7:0]        entry_blue,
  input  logic [7:0]        pixel_index,
  output logic              req_valid,
  output pte_pkg::req_t     req,
  input  logic              req_pop
);

  pte_pkg::req_t                     q [pte_pkg::QUEUE_DEPTH];
  logic [pte_pkg::QPTR_W-1:0]        wr_ptr;
  logic [pte_pkg::QPTR_W-1:0]        rd_ptr;
  logic [pte_pkg::QCNT_W-1:0]        count;
  logic [pte_pkg::QCNT_W-1:0]        count_next;
  logic                              push_ok;
  logic                              pop_ok;
  logic [7:0]                        idx;
  pte_pkg::req_t                     incoming;

  assign idx = (opcode == pte_pkg::OP_LOAD) ? entry_index : pixel_index;

  always_comb begin
    incoming.is_load  = (opcode == pte_pkg::OP_LOAD);
    incoming.in_range = ({1'b0, idx} < 9'(PALETTE_ENTRIES));
    incoming.index    = idx;
    incoming.rgb      = {entry_red, entry_green, entry_blue};
  end

  assign full      = (count == pte_pkg::QCNT_W'(pte_pkg::QUEUE_DEPTH));
  assign req_valid = (count != '0);
  assign req       = q[rd_ptr];
  assign push_ok   = push && !full;
  assign pop_ok    = req_pop && req_valid;

  always_comb begin
    count_next = count;
    if (push_ok && !pop_ok) begin
      count_next = count + pte_pkg::QCNT_W'(1);
    end else if (pop_ok && !push_ok) begin
      count_next = count - pte_pkg::QCNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      count <= count_next;
      if (push_ok) begin
        wr_ptr <= wr_ptr + pte_pkg::QPTR_W'(1);
      end
      if (pop_ok) begin
        rd_ptr <= rd_ptr + pte_pkg::QPTR_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push_ok) begin
      q[wr_ptr] <= incoming;
    end
  end

endmodule

[rtl/core/pte_back.sv]
// Back end: palette memory, pixel conversion and the result queue.
module pte_back #(
  parameter int unsigned PALETTE_ENTRIES = pte_pkg::PALETTE_ENTRIES
) (
  input  logic              clk,
  input  logic              rst,
  input  pte_pkg::cfg_t     cfg,
  input  logic              req_valid,
  input  pte_pkg::req_t     req,
  output logic              req_pop,
  output logic              empty,
  input  logic              pop,
  output pte_pkg::res_t     result
);

  localparam int unsigned PAL_AW       = $clog2(PALETTE_ENTRIES);
  localparam logic        KEY_IN_RANGE = (PALETTE_ENTRIES > 255);

  logic [23:0]                  mem [PALETTE_ENTRIES];
  logic [23:0]                  rd_data;
  logic [23:0]                  key_reg;
  logic [23:0]                  key_val;
  logic                         s1_valid;
  logic                         s1_in_range;
  logic                         s1_is_key;
  logic [23:0]                  s1_key;
  logic [23:0]                  ent;
  logic [7:0]                   er;
  pte_pkg::res_t                res;

  pte_pkg::res_t                oq [pte_pkg::QUEUE_DEPTH];
  logic [pte_pkg::QPTR_W-1:0]   o_wr;
  logic [pte_pkg::QPTR_W-1:0]   o_rd;
  logic [pte_pkg::QCNT_W-1:0]   o_count;
  logic [pte_pkg::QCNT_W-1:0]   o_count_next;
  logic [pte_pkg::QCNT_W-1:0]   in_flight;
  logic                         room;
  logic                         issue_rd;
  logic                         mem_we;
  logic                         o_pop_ok;

  assign in_flight = o_count + pte_pkg::QCNT_W'(s1_valid);
  assign room      = (in_flight < pte_pkg::QCNT_W'(pte_pkg::QUEUE_DEPTH));
  assign req_pop   = req_valid && (req.is_load || room);
  assign issue_rd  = req_pop && !req.is_load;
  assign mem_we    = req_pop && req.is_load && req.in_range;
  assign key_val   = KEY_IN_RANGE ? key_reg : 24'h000000;

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[req.index[PAL_AW-1:0]] <= req.rgb;
    end
    if (issue_rd) begin
      rd_data <= mem[req.index[PAL_AW-1:0]];
    end
  end

  always_ff @(posedge clk) begin
    if (mem_we && (req.index == pte_pkg::KEY_ENTRY)) begin
      key_reg <= req.rgb;
    end
    if (issue_rd) begin
      s1_in_range <= req.in_range;
      s1_is_key   <= (req.index == pte_pkg::KEY_ENTRY);
      s1_key      <= key_val;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else begin
      s1_valid <= issue_rd;
    end
  end

  assign ent = s1_in_range ? rd_data : 24'h000000;
  assign er  = ent[23:16];

  always_comb begin
    res.alpha_used = cfg.decal_name;
    if (cfg.fill_error) begin
      res.red   = pte_pkg::ZERO_BYTE;
      res.green = pte_pkg::FULL_ALPHA;
      res.blue  = pte_pkg::ZERO_BYTE;
      res.alpha = pte_pkg::FULL_ALPHA;
    end else if (cfg.decal_name && (s1_key == pte_pkg::GLASS_KEY)) begin
      res.red   = pte_pkg::FULL_ALPHA;
      res.green = pte_pkg::FULL_ALPHA;
      res.blue  = pte_pkg::FULL_ALPHA;
      res.alpha = er;
    end else if (cfg.decal_name && (s1_key != pte_pkg::COLOR_KEY)) begin
      res.red   = s1_key[23:16];
      res.green = s1_key[15:8];
      res.blue  = s1_key[7:0];
      res.alpha = pte_pkg::FULL_ALPHA - er;
    end else if (cfg.decal_name && s1_is_key) begin
      res.red   = pte_pkg::ZERO_BYTE;
      res.green = pte_pkg::ZERO_BYTE;
      res.blue  = pte_pkg::ZERO_BYTE;
      res.alpha = pte_pkg::ZERO_BYTE;
    end else begin
      res.red   = er;
      res.green = ent[15:8];
      res.blue  = ent[7:0];
      res.alpha = pte_pkg::FULL_ALPHA;
    end
  end

  assign empty    = (o_count == '0);
  assign result   = oq[o_rd];
  assign o_pop_ok = pop && !empty;

  always_comb begin
    o_count_next = o_count;
    if (s1_valid && !o_pop_ok) begin
      o_count_next = o_count + pte_pkg::QCNT_W'(1);
    end else if (o_pop_ok && !s1_valid) begin
      o_count_next = o_count - pte_pkg::QCNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      o_wr    <= '0;
      o_rd    <= '0;
      o_count <= '0;
    end else begin
      o_count <= o_count_next;
      if (s1_valid) begin
        o_wr <= o_wr + pte_pkg::QPTR_W'(1);
      end
      if (o_pop_ok) begin
        o_rd <= o_rd + pte_pkg::QPTR_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (s1_valid) begin
      oq[o_wr] <= res;
    end
  end

endmodule

[rtl/core/pte_regs.sv]
// Configuration register file behind the APB-style port.
module pte_regs (
  input  logic              clk,
  input  logic              rst,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [2:0]        paddr,
  input  logic [31:0]       pwdata,
  output logic [31:0]       prdata,
  output logic              pready,
  output pte_pkg::cfg_t     cfg
);

  logic decal_name;
  logic fill_error;
  logic wr_en;
  logic sel;

  assign pready = 1'b1;
  assign wr_en  = psel && penable && pwrite;
  assign sel    = paddr[pte_pkg::REG_SEL_BIT];

  always_ff @(posedge clk) begin
    if (rst) begin
      decal_name <= 1'b0;
      fill_error <= 1'b0;
    end else if (wr_en) begin
      case (sel)
        pte_pkg::REG_DECAL_NAME: decal_name <= pwdata[0];
        pte_pkg::REG_FILL_ERROR: fill_error <= pwdata[0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (sel)
      pte_pkg::REG_DECAL_NAME: prdata = {31'b0, decal_name};
      pte_pkg::REG_FILL_ERROR: prdata = {31'b0, fill_error};
      default:                 prdata = '0;
    endcase
  end

  assign cfg.decal_name = decal_name;
  assign cfg.fill_error = fill_error;

endmodule

[rtl/core/palette_texture_expand.sv]
// Top level of the palette index to RGBA expander.
// Load requests write one palette entry and give no result; convert requests give one RGBA
// pixel each. The block takes one request per clock while its input queue is not full and
// delivers one result per clock while results are popped, paced by the single-port palette
// memory, which performs one write or one read each cycle. A convert result passes through
// the input queue, the registered palette read and the result queue before it shows on the
// result ports. Both queues hold four entries, so either side may stall without stopping the
// other at once.
// Registers: decal_name at address 0 and fill_error at address 4; write them only while no
// request is in flight.
module palette_texture_expand #(
  parameter int unsigned PALETTE_ENTRIES = pte_pkg::PALETTE_ENTRIES
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        push,
  output logic        full,
  input  logic        opcode,
  input  logic [7:0]  entry_index,
  input  logic [7:0]  entry_red,
  input  logic [7:0]  entry_green,
  input  logic [7:0]  entry_blue,
  input  logic [7:0]  pixel_index,
  output logic        empty,
  input  logic        pop,
  output logic [7:0]  out_red,
  output logic [7:0]  out_green,
  output logic [7:0]  out_blue,
  output logic [7:0]  out_alpha,
  output logic        alpha_used,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  pte_pkg::cfg_t cfg;
  pte_pkg::req_t req;
  pte_pkg::res_t result;
  logic          req_valid;
  logic          req_pop;

  pte_regs u_regs (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  pte_front #(
    .PALETTE_ENTRIES (PALETTE_ENTRIES)
  ) u_front (
    .clk         (clk),
    .rst         (rst),
    .push        (push),
    .full        (full),
    .opcode      (opcode),
    .entry_index (entry_index),
    .entry_red   (entry_red),
    .entry_green (entry_green),
    .entry_blue  (entry_blue),
    .pixel_index (pixel_index),
    .req_valid   (req_valid),
    .req         (req),
    .req_pop     (req_pop)
  );

  pte_back #(
    .PALETTE_ENTRIES (PALETTE_ENTRIES)
  ) u_back (
    .clk       (clk),
    .rst       (rst),
    .cfg       (cfg),
    .req_valid (req_valid),
    .req       (req),
    .req_pop   (req_pop),
    .empty     (empty),
    .pop       (pop),
    .result    (result)
  );

  assign out_red    = result.red;
  assign out_green  = result.green;
  assign out_blue   = result.blue;
  assign out_alpha  = result.alpha;
  assign alpha_used = result.alpha_used;

endmodule

[rtl/core/pte_checker.sv]
// Port-level checker of the palette expander and its bind statement.
`include "palette_texture_expand_macros.svh"

module pte_checker (
  input logic        clk,
  input logic        rst,
  input logic        push,
  input logic        full,
  input logic        opcode,
  input logic [7:0]  entry_index,
  input logic [7:0]  entry_red,
  input logic [7:0]  entry_green,
  input logic [7:0]  entry_blue,
  input logic [7:0]  pixel_index,
  input logic        empty,
  input logic        pop,
  input logic [7:0]  out_red,
  input logic [7:0]  out_green,
  input logic [7:0]  out_blue,
  input logic [7:0]  out_alpha,
  input logic        alpha_used,
  input logic        psel,
  input logic        penable,
  input logic        pwrite,
  input logic [2:0]  paddr,
  input logic [31:0] pwdata,
  input logic [31:0] prdata,
  input logic        pready
);

  logic [32:0] res_bus;
  logic        waiting;

  assign res_bus = {out_red, out_green, out_blue, out_alpha, alpha_used};
  assign waiting = !empty && !pop;

  `PTE_ASSERT_ALWAYS(a_reset_empty, clk, rst |=> empty, "result queue not empty after reset")

  `PTE_ASSERT_ALWAYS(a_reset_not_full, clk, rst |=> !full, "request queue full after reset")

  `PTE_ASSERT_ALWAYS(a_pready_high, clk, pready, "pready dropped")

  `PTE_ASSERT(a_result_hold, clk, rst, waiting |=> !empty && $stable(res_bus), "result not held")

endmodule

bind palette_texture_expand pte_checker u_pte_checker (.*);
